/* rtl/core/mt_pkg.sv */
// ----------------------------------------------------------------------------
// MT19937 package
// Shared constants, sequencer states and datapath operation codes.
// ----------------------------------------------------------------------------
package mt_pkg;

  localparam int WORD_W       = 32;
  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;

  localparam logic [WORD_W-1:0] SEED_MULT    = 32'd69069;
  localparam logic [WORD_W-1:0] SEED_RESET   = 32'd4357;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_TW_PRE,
    ST_TW_RD,
    ST_TW_WR,
    ST_FETCH,
    ST_DELIV
  } state_t;

  // Operations of the shared word unit
  typedef enum logic [1:0] {
    UOP_SEED,
    UOP_TWIST,
    UOP_TEMPER
  } unit_op_t;

endpackage

/* rtl/core/mt_if.sv */
// ----------------------------------------------------------------------------
// MT19937 stream channels
// Valid/ready channels for the request beat and the random word beat.
// ----------------------------------------------------------------------------
interface mt_req_if;
  logic valid;
  logic ready;
  logic request;

  modport source (output valid, output request, input ready);
  modport sink   (input valid, input request, output ready);
endinterface

interface mt_word_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

/* rtl/core/mt_state_ram.sv */
// ----------------------------------------------------------------------------
// MT19937 state memory
// One write port, two read ports with registered read data and a read enable.
// ----------------------------------------------------------------------------
module mt_state_ram #(
  parameter int DEPTH  = mt_pkg::STATE_WORDS,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [ADDR_W-1:0]        waddr,
  input  logic [mt_pkg::WORD_W-1:0] wdata,
  input  logic                     re,
  input  logic [ADDR_W-1:0]        raddr_a,
  input  logic [ADDR_W-1:0]        raddr_b,
  output logic [mt_pkg::WORD_W-1:0] rdata_a,
  output logic [mt_pkg::WORD_W-1:0] rdata_b
);
  import mt_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

/* rtl/core/mt_word_unit.sv */
// ----------------------------------------------------------------------------
// MT19937 word unit
// Shared combinational unit: seed multiply, twist recurrence, tempering.
// ----------------------------------------------------------------------------
module mt_word_unit (
  input  mt_pkg::unit_op_t          op,
  input  logic [mt_pkg::WORD_W-1:0] a,
  input  logic [mt_pkg::WORD_W-1:0] b,
  input  logic [mt_pkg::WORD_W-1:0] c,
  output logic [mt_pkg::WORD_W-1:0] y
);
  import mt_pkg::*;

  logic [WORD_W-1:0] seed_y;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] twist_y;
  logic [WORD_W-1:0] t1, t2, t3, temper_y;

  // next seed word: low 32 bits of the product
  assign seed_y = a * SEED_MULT;

  // a = word k, b = word k+1, c = word k+offset
  assign mix     = (a & UPPER_MASK) | (b & LOWER_MASK);
  assign twist_y = c ^ (mix >> 1) ^ (b[0] ? TWIST_MATRIX : '0);

  // standard tempering
  assign t1       = a ^ (a >> 11);
  assign t2       = t1 ^ ((t1 << 7) & TEMPER_B);
  assign t3       = t2 ^ ((t2 << 15) & TEMPER_C);
  assign temper_y = t3 ^ (t3 >> 18);

  always_comb begin
    case (op)
      UOP_SEED:   y = seed_y;
      UOP_TWIST:  y = twist_y;
      UOP_TEMPER: y = temper_y;
      default:    y = a;
    endcase
  end

endmodule

/* rtl/core/mersenne_twister_generator.sv */
// A request beat passes ST_FETCH (memory read) and ST_DELIV (temper, output load) when words remain.
// Seeding (first request, or after a seed write) writes each of the STATE_WORDS words once.
// A twist runs ST_TW_PRE once, then ST_TW_RD and ST_TW_WR: two reads then one write per word on the memory.
// A new request is taken only in ST_IDLE, after the previous word has left ST_DELIV; ST_DELIV waits on a full output.
// Reset: synchronous active-low; state memory is not cleared, seeding fills it before use.
// ----------------------------------------------------------------------------
// MT19937 generator top level
// Sequencer around the state memory and the shared word unit.
// ----------------------------------------------------------------------------
module mersenne_twister_generator #(
  parameter int STATE_WORDS = mt_pkg::STATE_WORDS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mt_req_if.sink                    in_req,
  mt_word_if.source                 out_word,
  input  logic                      cfg_we,
  input  logic [mt_pkg::WORD_W-1:0] cfg_data
);
  import mt_pkg::*;

  localparam int ADDR_W = $clog2(STATE_WORDS);
  localparam int CNT_W  = $clog2(STATE_WORDS + 1);
  localparam int WRAP   = STATE_WORDS - TWIST_OFFSET;
  localparam logic [ADDR_W-1:0] LAST_IDX  = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] WRAP_IDX  = ADDR_W'(WRAP);
  localparam logic [ADDR_W-1:0] OFS_IDX   = ADDR_W'(TWIST_OFFSET);
  localparam logic [CNT_W-1:0]  LAST_LEFT = CNT_W'(STATE_WORDS - 1);

  state_t state_r, state_nxt;

  logic [ADDR_W-1:0] cnt_r;
  logic [ADDR_W-1:0] fetch_addr_r;
  logic [CNT_W-1:0]  pos_r;
  logic [CNT_W-1:0]  left_r;
  logic              seeded_r;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] x_r;
  logic [WORD_W-1:0] cur_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] out_word_r;

  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, ra_a, ra_b;
  logic [WORD_W-1:0] mem_wdata, rd_a, rd_b;
  unit_op_t          uop;
  logic [WORD_W-1:0] unit_y;

  logic req_beat;
  logic out_free;
  logic cnt_last;

  assign in_req.ready         = (state_r == ST_IDLE);
  assign req_beat             = in_req.valid && in_req.request;
  assign out_free             = !out_valid_r || out_word.ready;
  assign cnt_last             = (cnt_r == LAST_IDX);
  assign out_word.valid       = out_valid_r;
  assign out_word.random_word = out_word_r;

  mt_state_ram #(
    .DEPTH  (STATE_WORDS),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (ra_a),
    .raddr_b (ra_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  mt_word_unit u_unit (
    .op (uop),
    .a  ((state_r == ST_TW_WR) ? cur_r : ((state_r == ST_SEED) ? x_r : rd_a)),
    .b  (rd_a),
    .c  (rd_b),
    .y  (unit_y)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_beat) begin
          if (!seeded_r) begin
            state_nxt = ST_SEED;
          end else if (left_r == '0) begin
            state_nxt = ST_TW_PRE;
          end else begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_SEED:   if (cnt_last) state_nxt = ST_TW_PRE;
      ST_TW_PRE: state_nxt = ST_TW_RD;
      ST_TW_RD:  state_nxt = ST_TW_WR;
      ST_TW_WR:  state_nxt = cnt_last ? ST_FETCH : ST_TW_RD;
      ST_FETCH:  state_nxt = ST_DELIV;
      ST_DELIV:  if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // memory and unit controls
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = unit_y;
    mem_re    = 1'b0;
    ra_a      = fetch_addr_r;
    ra_b      = fetch_addr_r;
    uop       = UOP_TEMPER;
    case (state_r)
      ST_SEED: begin
        mem_we    = 1'b1;
        mem_wdata = x_r;
        uop       = UOP_SEED;
      end
      ST_TW_PRE: begin
        mem_re = 1'b1;
        ra_a   = '0;
      end
      ST_TW_RD: begin
        // word k+1 and word k+offset, both modulo the depth
        mem_re = 1'b1;
        ra_a   = cnt_last ? '0 : cnt_r + 1'b1;
        ra_b   = (cnt_r >= WRAP_IDX) ? cnt_r - WRAP_IDX : cnt_r + OFS_IDX;
      end
      ST_TW_WR: begin
        mem_we = 1'b1;
        uop    = UOP_TWIST;
      end
      ST_FETCH: begin
        mem_re = 1'b1;
      end
      default: begin
        uop = UOP_TEMPER;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      left_r      <= '0;
      seeded_r    <= 1'b0;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      case (state_r)
        ST_IDLE: begin
          if (req_beat) begin
            if (!seeded_r) begin
              x_r   <= seed_r | 32'd1;
              cnt_r <= '0;
            end else if (left_r == '0) begin
              cnt_r <= '0;
            end else begin
              fetch_addr_r <= pos_r[ADDR_W-1:0];
              pos_r        <= pos_r + 1'b1;
              left_r       <= left_r - 1'b1;
            end
          end
        end
        ST_SEED: begin
          x_r <= unit_y;
          if (cnt_last) begin
            cnt_r    <= '0;
            seeded_r <= 1'b1;
            pos_r    <= '0;
            left_r   <= '0;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_TW_RD: begin
          cur_r <= rd_a;
        end
        ST_TW_WR: begin
          if (cnt_last) begin
            cnt_r        <= '0;
            fetch_addr_r <= '0;
            pos_r        <= CNT_W'(1);
            left_r       <= LAST_LEFT;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: begin
          cnt_r <= cnt_r;
        end
      endcase

      // output register: load the tempered word, drop on a taken beat
      if (state_r == ST_DELIV && out_free) begin
        out_valid_r <= 1'b1;
        out_word_r  <= unit_y;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end

      // seed write forces reseeding on the next request
      if (cfg_we) begin
        seed_r   <= cfg_data;
        seeded_r <= 1'b0;
      end
    end
  end

  // checks
  a_cfg_unseeds: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !seeded_r)
    else $error("seed write did not clear seeded flag");

  a_pos_left: assert property (@(posedge clk) disable iff (!rst_n)
    (left_r == '0) || ((CNT_W+1)'(pos_r) + (CNT_W+1)'(left_r) == (CNT_W+1)'(STATE_WORDS)))
    else $error("read position and words left out of step");

  a_deliv_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DELIV && out_valid_r && !out_word.ready) |=> (state_r == ST_DELIV))
    else $error("result dropped while output beat stalled");

  a_seed_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && req_beat && !seeded_r) |=> (state_r == ST_SEED))
    else $error("request on unseeded state did not start seeding");

endmodule
